/* sv/dbic_pkg.sv */
// Shared types and constants of the debounced binary input channel.
`default_nettype none

package dbic_pkg;

  // Register map (word index, byte address is 4 * index)
  localparam int unsigned CFG_ADDR_W = 5;
  localparam logic [2:0] REG_ACTIVE   = 3'd0;
  localparam logic [2:0] REG_OPEN     = 3'd1;
  localparam logic [2:0] REG_CLOSE    = 3'd2;
  localparam logic [2:0] REG_DEBOUNCE = 3'd3;
  localparam logic [2:0] REG_PERIOD   = 3'd4;

  // Action codes for open and closed reports; both unmapped codes drop the report
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_SEND0   = 2'd1;
  localparam logic [1:0] ACT_SEND1   = 2'd2;
  localparam logic [1:0] ACT_NONE_HI = 2'd3;

  // Debounce level marker for "no level seen yet"
  localparam logic [1:0] DEB_UNKNOWN = 2'd2;
  localparam logic [7:0] DEB_MAX     = 8'hFF;

  localparam int unsigned PERIOD_W = 32;

  // Result queue geometry
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = 2;
  localparam int unsigned RQ_CW    = 3;

  typedef struct packed {
    logic                active;
    logic [1:0]          open_act;
    logic [1:0]          close_act;
    logic [7:0]          debounce;
    logic [PERIOD_W-1:0] period;
  } cfg_t;

  typedef struct packed {
    logic last;
    logic periodic;
    logic value;
  } entry_t;

  // Results of one tick, packed in emission order
  typedef struct packed {
    logic [1:0] cnt;
    entry_t     e0;
    entry_t     e1;
  } res_t;

endpackage

`default_nettype wire

/* sv/debounced_binary_input_channel_unit.sv */
// Top level of the debounced binary input channel.
//
// Each input word is one millisecond tick (in_tuser[0] = pin level valid, in_tdata[0] = pin
// level). The level, debounce and periodic-timer state are updated and the tick's reports
// are written to a four-word result queue at the clock edge that accepts it; out_* is driven
// from that registered queue. in_tready is high while the queue holds at most two words, so
// ticks flow at one per cycle as long as the output side drains; a tick that raises both a
// change report and a periodic report puts two words in the queue, and the queue's single
// read port sets the output rate. Registers (4-byte spacing):
// channel_active, open_action, close_action, debounce_ms, period_ms; write them while idle.
`default_nettype none

module debounced_binary_input_channel_unit
  import dbic_pkg::*;
#(
  parameter int unsigned PERIOD_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Tick stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [0] pin_level, [7:1] zero
  input  wire logic [0:0]            in_tuser,   // [0] pin_known
  // Report stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [7:0]            out_tdata,  // [0] send_value, [7:1] zero
  output logic      [0:0]            out_tuser,  // [0] from_periodic
  output logic                       out_tlast,  // last_of_run
  // Configuration
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic      [31:0]           cfg_prdata,
  output logic                       cfg_pready
);

  cfg_t   cfg;
  res_t   res;
  entry_t head;
  logic   tick;
  logic   room2;

  assign in_tready = room2;
  assign tick      = in_tvalid & in_tready;

  dbic_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  dbic_core #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (tick),
    .pin_known (in_tuser[0]),
    .pin_level (in_tdata[0]),
    .cfg       (cfg),
    .res       (res)
  );

  dbic_rq u_rq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res),
    .pop   (out_tready),
    .room2 (room2),
    .valid (out_tvalid),
    .head  (head)
  );

  // Drive the report word from the queue head
  assign out_tdata = {7'd0, head.value};
  assign out_tuser = head.periodic;
  assign out_tlast = head.last;

endmodule

`default_nettype wire

/* sv/dbic_cfg.sv */
// APB-style configuration register file of the channel.
`default_nettype none

module dbic_cfg
  import dbic_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic      [31:0]           cfg_prdata,
  output logic                       cfg_pready,
  output cfg_t                       cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[CFG_ADDR_W-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg        = cfg_r;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_ACTIVE:   cfg_r.active    <= cfg_pwdata[0];
        REG_OPEN:     cfg_r.open_act  <= cfg_pwdata[1:0];
        REG_CLOSE:    cfg_r.close_act <= cfg_pwdata[1:0];
        REG_DEBOUNCE: cfg_r.debounce  <= cfg_pwdata[7:0];
        REG_PERIOD:   cfg_r.period    <= cfg_pwdata[PERIOD_W-1:0];
        default:      ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_ACTIVE:   cfg_prdata = {31'd0, cfg_r.active};
      REG_OPEN:     cfg_prdata = {30'd0, cfg_r.open_act};
      REG_CLOSE:    cfg_prdata = {30'd0, cfg_r.close_act};
      REG_DEBOUNCE: cfg_prdata = {24'd0, cfg_r.debounce};
      REG_PERIOD:   cfg_prdata = cfg_r.period;
      default:      cfg_prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/dbic_core.sv */
// Per-tick level tracking, debounce, periodic timer and report generation.
`default_nettype none

module dbic_core
  import dbic_pkg::*;
#(
  parameter int unsigned PERIOD_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic tick,
  input  wire logic pin_known,
  input  wire logic pin_level,
  input  cfg_t      cfg,
  output res_t      res
);

  logic                   hw_known_r, hw_known_nxt;
  logic                   hw_level_r, hw_level_nxt;
  logic                   rep_known_r, rep_known_nxt;
  logic                   rep_level_r, rep_level_nxt;
  logic [1:0]             deb_level_r, deb_level_nxt;
  logic [7:0]             deb_el_r, deb_el_nxt;
  logic                   per_started_r, per_started_nxt;
  logic [PERIOD_BITS-1:0] per_el_r, per_el_nxt;

  logic                   blocked;
  logic                   chg_fire, per_fire;
  logic [PERIOD_W-1:0]    per_el_ext;
  logic [1:0]             action;
  logic                   act_ok, act_val;
  entry_t                 chg_e, per_e;

  // Next state of one tick
  always_comb begin
    hw_known_nxt    = hw_known_r;
    hw_level_nxt    = hw_level_r;
    rep_known_nxt   = rep_known_r;
    rep_level_nxt   = rep_level_r;
    deb_level_nxt   = deb_level_r;
    per_started_nxt = per_started_r;
    blocked         = 1'b0;
    chg_fire        = 1'b0;
    per_fire        = 1'b0;

    // Elapsed counters advance on every tick, saturating
    deb_el_nxt = (deb_el_r == DEB_MAX) ? deb_el_r : deb_el_r + 8'd1;
    per_el_nxt = (per_el_r == {PERIOD_BITS{1'b1}}) ? per_el_r
                                                   : per_el_r + 1'b1;

    if (cfg.active) begin
      if (pin_known) begin
        hw_known_nxt = 1'b1;
        hw_level_nxt = pin_level;
      end
      if (hw_known_nxt) begin
        if (cfg.debounce != 8'd0) begin
          // Restart the stability window on a new level
          if ({1'b0, hw_level_nxt} != deb_level_r) begin
            deb_level_nxt = {1'b0, hw_level_nxt};
            deb_el_nxt    = 8'd0;
          end
          blocked = deb_el_nxt < cfg.debounce;
        end
        if (!blocked && (!rep_known_r || hw_level_nxt != rep_level_r)) begin
          rep_known_nxt = 1'b1;
          rep_level_nxt = hw_level_nxt;
          chg_fire      = 1'b1;
        end
      end
      if (rep_known_nxt && cfg.period != '0) begin
        if (!per_started_r) begin
          per_started_nxt = 1'b1;
          per_el_nxt      = '0;
        end else if (per_el_ext >= cfg.period) begin
          per_el_nxt = '0;
          per_fire   = 1'b1;
        end
      end
    end
  end

  // Incremented count, widened for the compare against the period register
  assign per_el_ext = PERIOD_W'((per_el_r == {PERIOD_BITS{1'b1}}) ? per_el_r
                                                                  : per_el_r + 1'b1);

  // Map the reported level through its action
  assign action  = rep_level_nxt ? cfg.close_act : cfg.open_act;
  assign act_ok  = (action == ACT_SEND0) || (action == ACT_SEND1);
  assign act_val = (action == ACT_SEND1);

  assign chg_e = '{last: !(per_fire && act_ok), periodic: 1'b0, value: act_val};
  assign per_e = '{last: 1'b1, periodic: 1'b1, value: act_val};

  // Pack the results of this tick, change report first
  always_comb begin
    res = '0;
    if (tick && act_ok) begin
      if (chg_fire && per_fire) begin
        res.cnt = 2'd2;
        res.e0  = chg_e;
        res.e1  = per_e;
      end else if (chg_fire) begin
        res.cnt = 2'd1;
        res.e0  = chg_e;
      end else if (per_fire) begin
        res.cnt = 2'd1;
        res.e0  = per_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_known_r    <= 1'b0;
      hw_level_r    <= 1'b0;
      rep_known_r   <= 1'b0;
      rep_level_r   <= 1'b0;
      deb_level_r   <= DEB_UNKNOWN;
      deb_el_r      <= 8'd0;
      per_started_r <= 1'b0;
      per_el_r      <= '0;
    end else if (tick) begin
      hw_known_r    <= hw_known_nxt;
      hw_level_r    <= hw_level_nxt;
      rep_known_r   <= rep_known_nxt;
      rep_level_r   <= rep_level_nxt;
      deb_level_r   <= deb_level_nxt;
      deb_el_r      <= deb_el_nxt;
      per_started_r <= per_started_nxt;
      per_el_r      <= per_el_nxt;
    end
  end

`ifndef SYNTHESIS
  // The timer only runs once a level has been reported
  a_started_needs_report: assert property (@(posedge clk) disable iff (!rst_n)
    per_started_r |-> rep_known_r)
    else $error("periodic timer running without reported level");
`endif

endmodule

`default_nettype wire

/* sv/dbic_rq.sv */
// Result queue: takes up to two reports per cycle, hands out one word per cycle while the reader pops.
`default_nettype none

module dbic_rq
  import dbic_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  res_t      push,
  input  wire logic pop,
  output logic      room2,
  output logic      valid,
  output entry_t    head
);

  entry_t           mem [RQ_DEPTH];
  logic [RQ_AW-1:0] wp_r, wp_nxt;
  logic [RQ_AW-1:0] rp_r, rp_nxt;
  logic [RQ_CW-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign valid  = (cnt_r != '0);
  assign room2  = (cnt_r <= RQ_CW'(RQ_DEPTH - 2));
  assign head   = mem[rp_r];
  assign do_pop = pop & valid;

  // Advance pointers and fill count
  always_comb begin
    wp_nxt  = wp_r + RQ_AW'(push.cnt);
    rp_nxt  = rp_r + RQ_AW'(do_pop);
    cnt_nxt = cnt_r + RQ_CW'(push.cnt) - RQ_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the words in emission order
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wp_r] <= push.e0;
    end
    if (push.cnt == 2'd2) begin
      mem[wp_r + RQ_AW'(1)] <= push.e1;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RQ_CW'(RQ_DEPTH))
    else $error("result queue overfilled");
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> room2)
    else $error("result pushed without room");
  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2 && !do_pop) |=> cnt_r >= RQ_CW'(2))
    else $error("result queue count lost a word");
`endif

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the debounced binary input channel: random ticks against a predictor.
`timescale 1ns / 1ps

module testbench;
  import dbic_pkg::*;

  // Predicts the reports of each tick and checks the words seen on the report stream
  class channel_predictor;
    bit                active;
    bit [1:0]          open_act;
    bit [1:0]          close_act;
    bit [7:0]          debounce_ms;
    bit [PERIOD_W-1:0] period_ms;

    bit                pin_known;
    bit                pin_level;
    bit                sent_known;
    bit                sent_level;
    bit [1:0]          settle_level;
    bit [7:0]          settle_age;
    bit                timer_running;
    bit [PERIOD_W-1:0] timer_age;

    entry_t            expected_reports[$];
    int                mismatches;

    function new();
      settle_level = DEB_UNKNOWN;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_ACTIVE:   active      = value[0];
        REG_OPEN:     open_act    = value[1:0];
        REG_CLOSE:    close_act   = value[1:0];
        REG_DEBOUNCE: debounce_ms = value[7:0];
        REG_PERIOD:   period_ms   = value[PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    // Map the reported level through its action; zero when the report is dropped
    function bit action_value(output bit value);
      bit [1:0] act;
      act = sent_level ? close_act : open_act;
      value = (act == ACT_SEND1);
      return (act == ACT_SEND0) || (act == ACT_SEND1);
    endfunction

    function void take_tick(bit known, bit level);
      entry_t run [2];
      int     n;
      bit     blocked;
      bit     value;
      n = 0;
      blocked = 1'b0;
      // Time passes even while the channel is off
      if (settle_age != DEB_MAX) settle_age++;
      if (timer_age != '1) timer_age++;
      if (!active) return;
      if (known) begin
        pin_known = 1'b1;
        pin_level = level;
      end
      // Debounce, then report a level change
      if (pin_known) begin
        if (debounce_ms != 0) begin
          if ({1'b0, pin_level} != settle_level) begin
            settle_level = {1'b0, pin_level};
            settle_age = '0;
          end
          blocked = settle_age < debounce_ms;
        end
        if (!blocked && (!sent_known || pin_level != sent_level)) begin
          sent_known = 1'b1;
          sent_level = pin_level;
          if (action_value(value)) begin
            run[n].value = value;
            run[n].periodic = 1'b0;
            run[n].last = 1'b0;
            n++;
          end
        end
      end
      // Start the periodic timer once, then re-send on expiry
      if (sent_known && period_ms != 0) begin
        if (!timer_running) begin
          timer_running = 1'b1;
          timer_age = '0;
        end else if (timer_age >= period_ms) begin
          timer_age = '0;
          if (action_value(value)) begin
            run[n].value = value;
            run[n].periodic = 1'b1;
            run[n].last = 1'b0;
            n++;
          end
        end
      end
      if (n > 0) run[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_reports.push_back(run[i]);
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    task match_report(bit value, bit periodic, bit last);
      entry_t want;
      if (expected_reports.size() == 0) begin
        flag_mismatch($sformatf("unexpected report value=%0d periodic=%0d last=%0d",
                                value, periodic, last));
        return;
      end
      want = expected_reports.pop_front();
      if (value !== want.value)
        flag_mismatch($sformatf("send_value %0d, want %0d", value, want.value));
      if (periodic !== want.periodic)
        flag_mismatch($sformatf("from_periodic %0d, want %0d", periodic, want.periodic));
      if (last !== want.last)
        flag_mismatch($sformatf("last_of_run %0d, want %0d", last, want.last));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'd0;     // [0] pin_level, [7:1] zero
  logic [0:0]            in_tuser = 1'b0;     // [0] pin_known
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;           // [0] send_value, [7:1] zero
  logic [0:0]            out_tuser;           // [0] from_periodic
  logic                  out_tlast;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = 32'd0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  channel_predictor board = new();
  bit quiet = 1'b0;
  bit pressure_req = 1'b0;
  bit pressure_done = 1'b0;

  debounced_binary_input_channel_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Guard against a hung run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Report side: random stall bursts, one long hold-off to back up the block
  initial begin : drain_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (pressure_req && !pressure_done) begin
        pressure_done = 1'b1;
        stall_left = 119;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Sample the report stream away from the active edge
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.match_report(out_tdata[0], out_tuser[0], out_tlast);
  end

  task automatic send_tick(input bit known, input bit level);
    bit ready_seen;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, level};
    in_tuser  <= known;
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
    board.take_tick(known, level);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    bit ready_seen;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(negedge clk);
      ready_seen = cfg_pready;
      @(posedge clk);
    end while (!ready_seen);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    board.set_reg(idx, value);
  endtask

  // Drop valid and wait until every expected word is out and the block is idle
  task automatic settle();
    in_tvalid <= 1'b0;
    while (board.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input bit active, input bit [1:0] open_act,
                           input bit [1:0] close_act, input bit [7:0] deb,
                           input bit [31:0] period);
    settle();
    write_reg(REG_ACTIVE, {31'd0, active});
    write_reg(REG_OPEN, {30'd0, open_act});
    write_reg(REG_CLOSE, {30'd0, close_act});
    write_reg(REG_DEBOUNCE, {24'd0, deb});
    write_reg(REG_PERIOD, period);
  endtask

  // Level stretches sized around the debounce time, with bounces and unknown ticks
  task automatic pin_activity(input int count);
    int  left;
    int  len;
    int  pick;
    bit  lvl;
    left = count;
    lvl = 1'($urandom_range(0, 1));
    while (left > 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        lvl = ~lvl;
        len = $urandom_range(1, int'(board.debounce_ms) + 4);
        for (int i = 0; i < len && left > 0; i++, left--) begin
          if ($urandom_range(0, 9) == 0) send_tick(1'b0, 1'($urandom_range(0, 1)));
          else send_tick(1'b1, lvl);
        end
      end else if (pick < 8) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len && left > 0; i++, left--)
          send_tick(1'b1, 1'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len && left > 0; i++, left--)
          send_tick(1'b0, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic random_settings();
    bit [7:0]  deb;
    bit [31:0] period;
    case ($urandom_range(0, 7))
      0, 1, 2: deb = 8'd0;
      3, 4, 5: deb = 8'($urandom_range(1, 6));
      6:       deb = 8'($urandom_range(7, 40));
      default: deb = 8'($urandom_range(41, 254));
    endcase
    case ($urandom_range(0, 7))
      0:       period = 32'd0;
      1, 2, 3: period = $urandom_range(1, 8);
      4, 5:    period = $urandom_range(9, 40);
      6:       period = $urandom;
      default: period = 32'hFFFF_FFFF;
    endcase
    configure($urandom_range(0, 7) != 0, 2'($urandom_range(0, 3)),
              2'($urandom_range(0, 3)), deb, period);
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Channel off after reset: ticks only age the timers
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);

    // No level known yet, first report with timer start, change plus periodic in one tick
    configure(1'b1, ACT_SEND0, ACT_SEND1, 8'd0, 32'd1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);

    // Unmapped actions drop reports; debounce holds off a bouncing level
    configure(1'b1, ACT_NONE, ACT_NONE_HI, 8'd3, 32'd2);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);

    // Channel off again, then inverted mapping with a period that never expires
    configure(1'b0, ACT_SEND1, ACT_SEND0, 8'd0, 32'd3);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    configure(1'b1, ACT_SEND1, ACT_SEND0, 8'd0, 32'hFFFF_FFFF);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);

    // Random settings, random pin activity
    repeat (8) begin
      random_settings();
      pin_activity(100);
    end

    // Longest debounce time
    configure(1'b1, ACT_SEND0, ACT_SEND1, 8'd255, 32'd5);
    pin_activity(300);

    // Report on every tick while the receiver holds off
    configure(1'b1, ACT_SEND1, ACT_SEND0, 8'd0, 32'd1);
    pressure_req = 1'b1;
    pin_activity(200);

    // Full rate on both sides to finish
    quiet = 1'b1;
    configure(1'b1, ACT_SEND0, ACT_SEND1, 8'd2, 32'd3);
    pin_activity(50);
    random_settings();
    pin_activity(50);

    settle();
    repeat (10) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
